// ----- design/cmfs_pkg.sv -----
// Shared types and constants for the cube-map face select block.
package cmfs_pkg;

    localparam int DIR_W    = 16;
    localparam int CFG_W    = 13;
    localparam int CIDX_W   = 8;
    localparam int TEXEL_W  = 12;
    localparam int FACE_W   = 3;
    localparam int MAG_W    = 17;   // numerator / divisor width
    localparam int REM_W    = 18;   // partial remainder width

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    localparam logic [CIDX_W-1:0] REG_FACE_WIDTH  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_FACE_HEIGHT = 8'd1;
    localparam logic [CFG_W-1:0]  DIM_RESET       = 13'd256;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic [FACE_W-1:0]  face_index;
        logic [TEXEL_W-1:0] texel_col;
        logic [TEXEL_W-1:0] texel_row;
        logic               degenerate;
    } res_t;

    typedef struct packed {
        logic              valid;
        logic [FACE_W-1:0] face;
        logic              degenerate;
    } ctrl_t;

endpackage

// ----- design/cmfs_front.sv -----
// Major-axis selection and divider operand setup.
module cmfs_front
    import cmfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             dir_valid,
    input  dir_t             dir_data,
    output ctrl_t            ctrl,
    output logic [MAG_W-1:0] num_s,
    output logic [MAG_W-1:0] num_t,
    output logic [MAG_W-1:0] den
);

    ctrl_t             ctrl_reg, ctrl_next;
    logic [MAG_W-1:0]  num_s_reg, num_s_next;
    logic [MAG_W-1:0]  num_t_reg, num_t_next;
    logic [MAG_W-1:0]  den_reg, den_next;

    logic signed [MAG_W-1:0] xs, ys, zs, sc, tc;
    logic [DIR_W-1:0]        ax, ay, az, am;
    logic signed [REM_W-1:0] ns, nt;

    always_comb
    begin
        xs = MAG_W'(dir_data.dir_x);
        ys = MAG_W'(dir_data.dir_y);
        zs = MAG_W'(dir_data.dir_z);
        ax = xs[MAG_W-1] ? DIR_W'(-xs) : DIR_W'(xs);
        ay = ys[MAG_W-1] ? DIR_W'(-ys) : DIR_W'(ys);
        az = zs[MAG_W-1] ? DIR_W'(-zs) : DIR_W'(zs);
        ctrl_next.valid      = dir_valid;
        ctrl_next.degenerate = (xs == '0) && (ys == '0) && (zs == '0);
        // ties favor x, then y; zero counts as negative
        priority if (ax >= ay && ax >= az)
        begin
            am = ax;
            tc = -ys;
            if (xs > 0)
            begin
                ctrl_next.face = FACE_PX;
                sc = -zs;
            end
            else
            begin
                ctrl_next.face = FACE_NX;
                sc = zs;
            end
        end
        else if (ay >= az)
        begin
            am = ay;
            sc = xs;
            if (ys > 0)
            begin
                ctrl_next.face = FACE_PY;
                tc = zs;
            end
            else
            begin
                ctrl_next.face = FACE_NY;
                tc = -zs;
            end
        end
        else
        begin
            am = az;
            tc = -ys;
            if (zs > 0)
            begin
                ctrl_next.face = FACE_PZ;
                sc = xs;
            end
            else
            begin
                ctrl_next.face = FACE_NZ;
                sc = -xs;
            end
        end
        ns = $signed({2'b00, am}) + REM_W'(sc);
        nt = $signed({2'b00, am}) + REM_W'(tc);
        num_s_next = ns[REM_W-1] ? '0 : ns[MAG_W-1:0];
        num_t_next = nt[REM_W-1] ? '0 : nt[MAG_W-1:0];
        den_next   = {am, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            num_s_reg <= '0;
            num_t_reg <= '0;
            den_reg   <= '0;
        end
        else if (en)
        begin
            ctrl_reg  <= ctrl_next;
            num_s_reg <= num_s_next;
            num_t_reg <= num_t_next;
            den_reg   <= den_next;
        end
    end

    assign ctrl  = ctrl_reg;
    assign num_s = num_s_reg;
    assign num_t = num_t_reg;
    assign den   = den_reg;

endmodule

// ----- design/cmfs_div_stage.sv -----
// One quotient bit of the s and t restoring dividers.
module cmfs_div_stage
    import cmfs_pkg::*;
#(
    parameter int Q_W   = 17,
    parameter bit FIRST = 1'b0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  ctrl_t            ctrl_in,
    input  logic [REM_W-1:0] rem_s_in,
    input  logic [REM_W-1:0] rem_t_in,
    input  logic [Q_W-1:0]   q_s_in,
    input  logic [Q_W-1:0]   q_t_in,
    input  logic [MAG_W-1:0] den_in,
    output ctrl_t            ctrl_out,
    output logic [REM_W-1:0] rem_s_out,
    output logic [REM_W-1:0] rem_t_out,
    output logic [Q_W-1:0]   q_s_out,
    output logic [Q_W-1:0]   q_t_out,
    output logic [MAG_W-1:0] den_out
);

    ctrl_t            ctrl_reg;
    logic [REM_W-1:0] rem_s_reg, rem_s_next, rem_t_reg, rem_t_next;
    logic [Q_W-1:0]   q_s_reg, q_s_next, q_t_reg, q_t_next;
    logic [MAG_W-1:0] den_reg;
    logic [REM_W-1:0] ps, pt, dx;

    always_comb
    begin
        dx = {1'b0, den_in};
        ps = FIRST ? rem_s_in : {rem_s_in[REM_W-2:0], 1'b0};
        pt = FIRST ? rem_t_in : {rem_t_in[REM_W-2:0], 1'b0};
        rem_s_next = (ps >= dx) ? ps - dx : ps;
        rem_t_next = (pt >= dx) ? pt - dx : pt;
        q_s_next   = {q_s_in[Q_W-2:0], ps >= dx};
        q_t_next   = {q_t_in[Q_W-2:0], pt >= dx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            rem_s_reg <= '0;
            rem_t_reg <= '0;
            q_s_reg   <= '0;
            q_t_reg   <= '0;
            den_reg   <= '0;
        end
        else if (en)
        begin
            ctrl_reg  <= ctrl_in;
            rem_s_reg <= rem_s_next;
            rem_t_reg <= rem_t_next;
            q_s_reg   <= q_s_next;
            q_t_reg   <= q_t_next;
            den_reg   <= den_in;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign rem_s_out = rem_s_reg;
    assign rem_t_out = rem_t_reg;
    assign q_s_out   = q_s_reg;
    assign q_t_out   = q_t_reg;
    assign den_out   = den_reg;

endmodule

// ----- design/cmfs_texel.sv -----
// Coordinate to texel scaling and the result register.
module cmfs_texel
    import cmfs_pkg::*;
#(
    parameter int Q_W  = 17,
    parameter int FRAC = 16,
    parameter int SW   = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ctrl_t         ctrl_in,
    input  logic [Q_W-1:0] q_s,
    input  logic [Q_W-1:0] q_t,
    input  logic [SW-1:0] span_w,
    input  logic [SW-1:0] span_h,
    output logic          res_valid,
    output res_t          res_data
);

    localparam int PW = Q_W + SW;
    localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC;

    logic             valid_reg;
    res_t             res_reg, res_next;
    logic [Q_W-1:0]   cs, ct;
    logic [PW-1:0]    ps, pt;
    logic [PW+TEXEL_W-1:0] es, et;

    always_comb
    begin
        cs = (q_s > ONE) ? ONE : q_s;
        ct = (q_t > ONE) ? ONE : q_t;
        ps = PW'(cs) * PW'(span_w);
        pt = PW'(ct) * PW'(span_h);
        es = {{TEXEL_W{1'b0}}, ps};
        et = {{TEXEL_W{1'b0}}, pt};
        res_next.degenerate = ctrl_in.degenerate;
        if (ctrl_in.degenerate)
        begin
            res_next.face_index = FACE_NX;
            res_next.texel_col  = '0;
            res_next.texel_row  = '0;
        end
        else
        begin
            res_next.face_index = ctrl_in.face;
            res_next.texel_col  = es[FRAC +: TEXEL_W];
            res_next.texel_row  = et[FRAC +: TEXEL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctrl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res_data  = res_reg;

endmodule

// ----- design/cube_map_face_select.sv -----
// Top level of the cube-map face select and texel addressing pipeline.
// Usage:
//   dir channel: one direction request (dir_x, dir_y, dir_z, signed Q2.14)
//     is taken on each edge with dir_valid high and dir_stall low.
//   res channel: face_index, texel_col, texel_row, degenerate; taken on
//     each edge with res_valid high and res_stall low.
//   cfg channel: reg 0 face_width, reg 1 face_height (13 bits); cfg_ready
//     is always high. Write only while the pipeline is empty.
// Pipeline: operand stage, one divider stage per quotient bit, then the
//   texel multiply register, between acceptance and res_valid.
// Throughput: one request per cycle unless stalled; the s and t dividers
//   retire a quotient bit per stage, so each stage holds its own request.
// Stall: when the result register holds a request and res_stall is high,
//   every stage freezes and dir_stall rises; nothing is lost or repeated.
// Reset: all valid bits clear, face_width and face_height return to 256.
module cube_map_face_select
    import cmfs_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int MAX_FACE_DIM    = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dir_valid,
    output logic              dir_stall,
    input  dir_t              dir_data,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int Q_W  = COORD_FRAC_BITS + 1;
    localparam int SW   = $clog2(MAX_FACE_DIM);
    localparam int DW   = (CFG_W > SW + 1) ? CFG_W : SW + 1;
    localparam logic [DW-1:0] MAXD = DW'(MAX_FACE_DIM);

    logic en;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [DW-1:0]    cw, ch;
    logic [SW-1:0]    span_w, span_h;

    ctrl_t            ctrl [0:Q_W];
    logic [REM_W-1:0] rem_s [0:Q_W];
    logic [REM_W-1:0] rem_t [0:Q_W];
    logic [Q_W-1:0]   q_s [0:Q_W];
    logic [Q_W-1:0]   q_t [0:Q_W];
    logic [MAG_W-1:0] den [0:Q_W];
    logic [MAG_W-1:0] num_s, num_t;

    // whole pipeline advances unless the result is held by the receiver
    assign en        = !(res_valid && res_stall);
    assign dir_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FACE_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == REG_FACE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // zero counts as one, above the maximum saturates
    always_comb
    begin
        cw = DW'(width_reg);
        ch = DW'(height_reg);
        if (cw == '0)
            cw = DW'(1);
        else if (cw > MAXD)
            cw = MAXD;
        if (ch == '0)
            ch = DW'(1);
        else if (ch > MAXD)
            ch = MAXD;
        span_w = SW'(cw - DW'(1));
        span_h = SW'(ch - DW'(1));
    end

    cmfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .dir_valid (dir_valid),
        .dir_data  (dir_data),
        .ctrl      (ctrl[0]),
        .num_s     (num_s),
        .num_t     (num_t),
        .den       (den[0])
    );

    assign rem_s[0] = {1'b0, num_s};
    assign rem_t[0] = {1'b0, num_t};
    assign q_s[0]   = '0;
    assign q_t[0]   = '0;

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < Q_W; i++)
    begin : g_div
        cmfs_div_stage #(
            .Q_W   (Q_W),
            .FIRST (i == 0)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctrl_in   (ctrl[i]),
            .rem_s_in  (rem_s[i]),
            .rem_t_in  (rem_t[i]),
            .q_s_in    (q_s[i]),
            .q_t_in    (q_t[i]),
            .den_in    (den[i]),
            .ctrl_out  (ctrl[i+1]),
            .rem_s_out (rem_s[i+1]),
            .rem_t_out (rem_t[i+1]),
            .q_s_out   (q_s[i+1]),
            .q_t_out   (q_t[i+1]),
            .den_out   (den[i+1])
        );
    end

    cmfs_texel #(
        .Q_W  (Q_W),
        .FRAC (COORD_FRAC_BITS),
        .SW   (SW)
    ) u_texel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctrl_in   (ctrl[Q_W]),
        .q_s       (q_s[Q_W]),
        .q_t       (q_t[Q_W]),
        .span_w    (span_w),
        .span_h    (span_h),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

endmodule

// ----- design/cmfs_checker.sv -----
// Port-level checks for the cube-map face select block, with its bind.
module cmfs_props
    import cmfs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic dir_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data,
    input logic cfg_ready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        dir_stall |-> res_valid && res_stall)
        else $error("request stalled without downstream stall");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.degenerate |->
            res_data.face_index == FACE_NX && res_data.texel_col == '0 &&
            res_data.texel_row == '0)
        else $error("degenerate result not -x at texel 0,0");

    a_face: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.face_index <= FACE_NZ && cfg_ready)
        else $error("face index out of range");

endmodule

bind cube_map_face_select cmfs_props u_cmfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .dir_stall (dir_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_ready (cfg_ready)
);
